### hw/rtl/qfr_pkg.sv
// qfr_pkg: widths, types and register codes for the quaternion frame rotation block
// used by every rtl file of the block; depends on nothing

package qfr_pkg;

  // field widths
  localparam int VEC_W  = 24;
  localparam int QUAT_W = 16;
  localparam int QUAT_F = 14;

  // derived arithmetic widths
  localparam int PROD_W  = 2 * QUAT_W;
  localparam int COEF_W  = PROD_W + 2;
  localparam int MUL_W   = COEF_W + VEC_W;
  localparam int ACC_W   = MUL_W + 2;
  localparam int SHIFT   = 2 * QUAT_F;
  localparam int TDATA_W = ((3 * VEC_W + 7) / 8) * 8;

  // configuration port
  localparam int NUM_REGS = 4;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int ADDR_W   = IDX_W + 2;
  localparam int APB_W    = 32;

  localparam logic [IDX_W-1:0] REG_QUAT_W = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_QUAT_X = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_QUAT_Y = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_QUAT_Z = IDX_W'(3);

  localparam logic KIND_BODY_TO_INERTIAL = 1'b1;

  typedef logic signed [QUAT_W-1:0] qpart_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [VEC_W-1:0]  comp_t;

  typedef struct packed {
    qpart_t w;
    qpart_t x;
    qpart_t y;
    qpart_t z;
  } quat_t;

  typedef struct packed {
    prod_t ww;
    prod_t xx;
    prod_t yy;
    prod_t zz;
    prod_t xy;
    prod_t xz;
    prod_t yz;
    prod_t wx;
    prod_t wy;
    prod_t wz;
  } prods_t;

  localparam qpart_t QUAT_W_RESET = qpart_t'(1) <<< QUAT_F;

endpackage

### hw/rtl/qfr_regs.sv
// qfr_regs: apb register file holding the orientation quaternion
// depends on qfr_pkg

module qfr_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qfr_pkg::ADDR_W-1:0]     paddr,
  input  logic [qfr_pkg::APB_W-1:0]      pwdata,
  output logic [qfr_pkg::APB_W-1:0]      prdata,
  output qfr_pkg::quat_t                 quat
);

  logic                         wr;
  logic [qfr_pkg::IDX_W-1:0]    idx;
  logic [qfr_pkg::QUAT_W-1:0]   rd;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[qfr_pkg::ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.w <= qfr_pkg::QUAT_W_RESET;
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
    end else if (wr) begin
      case (idx)
        qfr_pkg::REG_QUAT_W: quat.w <= pwdata[qfr_pkg::QUAT_W-1:0];
        qfr_pkg::REG_QUAT_X: quat.x <= pwdata[qfr_pkg::QUAT_W-1:0];
        qfr_pkg::REG_QUAT_Y: quat.y <= pwdata[qfr_pkg::QUAT_W-1:0];
        qfr_pkg::REG_QUAT_Z: quat.z <= pwdata[qfr_pkg::QUAT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      qfr_pkg::REG_QUAT_W: rd = quat.w;
      qfr_pkg::REG_QUAT_X: rd = quat.x;
      qfr_pkg::REG_QUAT_Y: rd = quat.y;
      qfr_pkg::REG_QUAT_Z: rd = quat.z;
      default:             rd = '0;
    endcase
  end

  assign prdata = qfr_pkg::APB_W'(rd);

endmodule

### hw/rtl/qfr_coef.sv
// qfr_coef: two pipeline stages, quaternion pair products then the rotation matrix
// depends on qfr_pkg

module qfr_coef (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  qfr_pkg::comp_t       vec_in [3],
  input  qfr_pkg::quat_t       quat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qfr_pkg::coef_t       mat [3][3],
  output qfr_pkg::comp_t       vec_out [3]
);

  logic                va, vb;
  logic                ready_a, ready_b;
  qfr_pkg::prods_t     prods;
  logic                kind_a;
  qfr_pkg::comp_t      vec_a [3];

  qfr_pkg::coef_t      swx, swy, swz;
  qfr_pkg::coef_t      ww, xx, yy, zz, xy, xz, yz;
  qfr_pkg::coef_t      mat_next [3][3];

  assign ready_b  = !vb || out_ready;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;
  assign out_valid = vb;

  // stage a: the ten pair products of the quaternion
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      prods.ww <= quat.w * quat.w;
      prods.xx <= quat.x * quat.x;
      prods.yy <= quat.y * quat.y;
      prods.zz <= quat.z * quat.z;
      prods.xy <= quat.x * quat.y;
      prods.xz <= quat.x * quat.z;
      prods.yz <= quat.y * quat.z;
      prods.wx <= quat.w * quat.x;
      prods.wy <= quat.w * quat.y;
      prods.wz <= quat.w * quat.z;
      kind_a   <= kind;
      vec_a    <= vec_in;
    end
  end

  // scalar-part terms change sign with the direction
  always_comb begin
    ww = qfr_pkg::coef_t'(prods.ww);
    xx = qfr_pkg::coef_t'(prods.xx);
    yy = qfr_pkg::coef_t'(prods.yy);
    zz = qfr_pkg::coef_t'(prods.zz);
    xy = qfr_pkg::coef_t'(prods.xy);
    xz = qfr_pkg::coef_t'(prods.xz);
    yz = qfr_pkg::coef_t'(prods.yz);
    if (kind_a == qfr_pkg::KIND_BODY_TO_INERTIAL) begin
      swx = qfr_pkg::coef_t'(prods.wx);
      swy = qfr_pkg::coef_t'(prods.wy);
      swz = qfr_pkg::coef_t'(prods.wz);
    end else begin
      swx = -qfr_pkg::coef_t'(prods.wx);
      swy = -qfr_pkg::coef_t'(prods.wy);
      swz = -qfr_pkg::coef_t'(prods.wz);
    end
    mat_next[0][0] = ww + xx - yy - zz;
    mat_next[0][1] = (xy - swz) <<< 1;
    mat_next[0][2] = (xz + swy) <<< 1;
    mat_next[1][0] = (xy + swz) <<< 1;
    mat_next[1][1] = ww - xx + yy - zz;
    mat_next[1][2] = (yz - swx) <<< 1;
    mat_next[2][0] = (xz - swy) <<< 1;
    mat_next[2][1] = (yz + swx) <<< 1;
    mat_next[2][2] = ww - xx - yy + zz;
  end

  // stage b: matrix coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      mat     <= mat_next;
      vec_out <= vec_a;
    end
  end

endmodule

### hw/rtl/qfr_mac.sv
// qfr_mac: two pipeline stages, nine coefficient-by-component products then row sums
// depends on qfr_pkg

module qfr_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qfr_pkg::coef_t       mat [3][3],
  input  qfr_pkg::comp_t       vec [3],
  output logic                 out_valid,
  input  logic                 out_ready,
  output qfr_pkg::acc_t        acc [3]
);

  localparam qfr_pkg::acc_t RND = qfr_pkg::acc_t'(1) <<< (qfr_pkg::SHIFT - 1);

  logic                va, vb;
  logic                ready_a, ready_b;
  qfr_pkg::mul_t       mul [3][3];

  assign ready_b   = !vb || out_ready;
  assign ready_a   = !va || ready_b;
  assign in_ready  = ready_a;
  assign out_valid = vb;

  // stage a: one multiplier per matrix entry
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mul[r][c] <= mat[r][c] * vec[c];
        end
      end
    end
  end

  // stage b: row sums with the half-lsb rounding offset
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= qfr_pkg::acc_t'(mul[r][0]) + qfr_pkg::acc_t'(mul[r][1])
                + qfr_pkg::acc_t'(mul[r][2]) + RND;
      end
    end
  end

endmodule

### hw/rtl/qfr_round.sv
// qfr_round: output stage, drops the fraction bits and clips to the vector range
// depends on qfr_pkg

module qfr_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qfr_pkg::acc_t        acc [3],
  output logic                 out_valid,
  input  logic                 out_ready,
  output qfr_pkg::comp_t       rot [3],
  output logic                 saturated
);

  localparam int HI_LSB = qfr_pkg::SHIFT + qfr_pkg::VEC_W - 1;
  localparam qfr_pkg::comp_t VMAX = {1'b0, {(qfr_pkg::VEC_W-1){1'b1}}};
  localparam qfr_pkg::comp_t VMIN = {1'b1, {(qfr_pkg::VEC_W-1){1'b0}}};

  logic                v;
  logic [2:0]          clip;
  qfr_pkg::comp_t      rot_next [3];

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  // clip when the bits above the result are not a plain sign extension
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip[r] = !((&acc[r][qfr_pkg::ACC_W-1:HI_LSB]) || !(|acc[r][qfr_pkg::ACC_W-1:HI_LSB]));
      if (clip[r]) begin
        rot_next[r] = acc[r][qfr_pkg::ACC_W-1] ? VMIN : VMAX;
      end else begin
        rot_next[r] = acc[r][HI_LSB:qfr_pkg::SHIFT];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rot       <= rot_next;
      saturated <= |clip;
    end
  end

endmodule

### hw/rtl/quaternion_frame_rotation.sv
// quaternion_frame_rotation: top level, apb quaternion registers and the rotation pipeline
// depends on qfr_pkg, qfr_regs, qfr_coef, qfr_mac, qfr_round

// Rotates a signed integer 3-vector by the quaternion held in the apb registers, inertial to
// body (tuser 0) or body to inertial (tuser 1), with Q1.14 quaternion parts, round to nearest
// and saturation flagged on m_tuser. The pipeline takes one word per clock while m_tready
// does not stall it; the stages are the quaternion pair products, the matrix coefficients,
// nine coefficient-by-component multipliers, the row sums and the clip register. Each stage
// holds its word while the stage after it is full and stalled, so back pressure on m_tready
// reaches s_tready only once every stage is occupied.

module quaternion_frame_rotation (
  input  logic                            clk,
  input  logic                            rst,
  // apb configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qfr_pkg::ADDR_W-1:0]      paddr,
  input  logic [qfr_pkg::APB_W-1:0]       pwdata,
  output logic [qfr_pkg::APB_W-1:0]       prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [qfr_pkg::TDATA_W-1:0]     s_tdata,  // vec_x, vec_y, vec_z
  input  logic                            s_tuser,  // kind
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [qfr_pkg::TDATA_W-1:0]     m_tdata,  // rot_x, rot_y, rot_z
  output logic                            m_tuser   // saturated
);

  localparam int VW = qfr_pkg::VEC_W;

  qfr_pkg::quat_t   quat;
  qfr_pkg::comp_t   vec_in [3];
  qfr_pkg::coef_t   mat [3][3];
  qfr_pkg::comp_t   vec_c [3];
  qfr_pkg::acc_t    acc [3];
  qfr_pkg::comp_t   rot [3];
  logic             coef_valid, coef_ready;
  logic             mac_valid, mac_ready;

  assign pready = 1'b1;

  // unpack the input word
  assign vec_in[0] = s_tdata[VW-1:0];
  assign vec_in[1] = s_tdata[2*VW-1:VW];
  assign vec_in[2] = s_tdata[3*VW-1:2*VW];

  qfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .quat    (quat)
  );

  qfr_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .vec_in    (vec_in),
    .quat      (quat),
    .out_valid (coef_valid),
    .out_ready (coef_ready),
    .mat       (mat),
    .vec_out   (vec_c)
  );

  qfr_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coef_valid),
    .in_ready  (coef_ready),
    .mat       (mat),
    .vec       (vec_c),
    .out_valid (mac_valid),
    .out_ready (mac_ready),
    .acc       (acc)
  );

  qfr_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mac_valid),
    .in_ready  (mac_ready),
    .acc       (acc),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .rot       (rot),
    .saturated (m_tuser)
  );

  // pack the output word
  assign m_tdata = qfr_pkg::TDATA_W'({rot[2], rot[1], rot[0]});

endmodule

### hw/rtl/qfr_checker.sv
// qfr_checker: port-level assertions for quaternion_frame_rotation, bound to the top level
// depends on qfr_pkg

module qfr_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [qfr_pkg::TDATA_W-1:0]     m_tdata,
  input  logic                            m_tuser
);

  localparam int VW = qfr_pkg::VEC_W;
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // pipeline is empty after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a clipped word has at least one component at a bound
  a_clip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[VW-1:0] == VMAX || m_tdata[VW-1:0] == VMIN ||
      m_tdata[2*VW-1:VW] == VMAX || m_tdata[2*VW-1:VW] == VMIN ||
      m_tdata[3*VW-1:2*VW] == VMAX || m_tdata[3*VW-1:2*VW] == VMIN)
    else $error("saturated flag without a clipped component");

  // with m_tready held high, an accepted word comes out of the pipeline and raises m_tvalid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("word lost in the pipeline");

endmodule

bind quaternion_frame_rotation qfr_checker u_qfr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
